// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== design/bnms_pkg.sv =====
`default_nettype none

package bnms_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam int PCT_W = 7;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd40;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_READ_ALT = 2'd3;

    typedef enum logic [2:0] {
        ST_APPENDED = 3'd0,
        ST_KEPT     = 3'd1,
        ST_REPLACED = 3'd2,
        ST_FULL     = 3'd3,
        ST_READ     = 3'd4,
        ST_CLEARED  = 3'd5
    } status_code_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [6:0]         read_index;
        logic [2:0]         box_class;
        logic [10:0]        box_score;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
    } in_item_t;

    typedef struct packed {
        status_code_t       status;
        logic [6:0]         entry_index;
        logic [7:0]         entry_count;
        logic [2:0]         out_class;
        logic [10:0]        out_score;
        logic [14:0]        out_width;
        logic [14:0]        out_height;
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
    } out_result_t;

    typedef struct packed {
        logic [2:0]         cls;
        logic [10:0]        score;
        logic [14:0]        wid;
        logic [14:0]        hei;
        logic signed [15:0] left;
        logic signed [15:0] top;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic flush;
        logic rd_issue;
        logic finish;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic pipe_empty;
        logic hit;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/per_class_box_nms_table.sv =====
// Per-class box suppression table: holds up to TABLE_DEPTH detection boxes
// and, on insert, walks the stored boxes from entry 0 upward, stopping at the
// first box of the same class whose intersection over union exceeds
// overlap_percent (tested exactly as inter*100 > percent*union). The new box
// replaces that entry only when its score is strictly higher; with no match it
// is appended, or reported as dropped when the table is full. Stored entries
// are read from one RAM port, one per cycle, into a five-stage overlap
// pipeline. An insert finishes once the walk hits or every stored box has
// drained through the pipeline; a read does a single RAM read and a clear
// only resets the count. One item is in work at a time, and the next item
// is taken while the previous result still waits in the output register.
`default_nettype none

module per_class_box_nms_table
    import bnms_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_item,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_result_t           out_result,
    input  wire logic             cfg_we,
    input  wire logic [PCT_W-1:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    bnms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_item.opcode),
        .in_stall  (in_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bnms_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_item    (in_item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

endmodule

`default_nettype wire

// ===== design/bnms_ram.sv =====
`default_nettype none

module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/bnms_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module bnms_ctrl
    import bnms_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_opcode,
    output logic            in_stall,
    input  wire stat_t      stat,
    output cmd_t            cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_READ   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (in_opcode) inside
                        OP_INSERT:           state_next = S_SCAN;
                        OP_CLEAR:            state_next = S_FINISH;
                        OP_READ, OP_READ_ALT: state_next = S_READ;
                        default:             state_next = S_READ;
                    endcase
                end
            end
            S_SCAN:
            begin
                // The first hit out of the overlap pipeline ends the walk; later
                // entries still in flight are thrown away.
                if (stat.hit)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.scan_done && stat.pipe_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.issue = !stat.scan_done;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    `ASSERT_PROP(a_one_item_at_a_time, in_valid && !in_stall |=> in_stall)

endmodule

`default_nettype wire

// ===== design/bnms_dp.sv =====
`default_nettype none

`include "assert_macros.svh"

module bnms_dp
    import bnms_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output stat_t                 stat,
    input  wire in_item_t         in_item,
    input  wire logic             cfg_we,
    input  wire logic [PCT_W-1:0] cfg_wdata,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_result_t           out_result
);

    // Control state.
    logic [PCT_W-1:0]   pct_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] scan_addr_reg;
    logic               found_reg;
    logic               out_valid_reg;
    logic               v0_reg;
    logic               va_reg;
    logic               vb_reg;
    logic               vc_reg;
    logic               vd_reg;

    // Payload.
    in_item_t           item_reg;
    logic [29:0]        area_new_reg;
    logic               better_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    out_result_t        out_result_reg;

    logic [IDX_W-1:0]   idx0_reg;
    logic [IDX_W-1:0]   idx_a_reg;
    logic               cand_a_reg;
    logic [14:0]        iw_a_reg;
    logic [14:0]        ih_a_reg;
    logic [14:0]        wid_a_reg;
    logic [14:0]        hei_a_reg;
    logic [10:0]        score_a_reg;

    logic [IDX_W-1:0]   idx_b_reg;
    logic               cand_b_reg;
    logic [29:0]        inter_b_reg;
    logic [29:0]        area_e_b_reg;
    logic [10:0]        score_b_reg;

    logic [IDX_W-1:0]   idx_c_reg;
    logic               cand_c_reg;
    logic [30:0]        uni_c_reg;
    logic [36:0]        inter100_c_reg;
    logic [10:0]        score_c_reg;

    logic [IDX_W-1:0]   idx_d_reg;
    logic               cand_d_reg;
    logic [37:0]        prod_d_reg;
    logic [36:0]        inter100_d_reg;
    logic [10:0]        score_d_reg;

    // Table memory.
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    entry_t             rd_entry;
    entry_t             new_entry;

    assign new_entry.cls   = item_reg.box_class;
    assign new_entry.score = item_reg.box_score;
    assign new_entry.wid   = item_reg.box_width;
    assign new_entry.hei   = item_reg.box_height;
    assign new_entry.left  = item_reg.box_left;
    assign new_entry.top   = item_reg.box_top;

    assign mem_re    = cmd.issue || cmd.rd_issue;
    assign mem_raddr = cmd.rd_issue ? IDX_W'(item_reg.read_index)
                                    : scan_addr_reg[IDX_W-1:0];
    assign rd_entry  = entry_t'(mem_rdata);

    bnms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (new_entry),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Stage A: edges of the intersection rectangle.
    logic signed [16:0] n_l, n_r, e_l, e_r, n_t, n_b, e_t, e_b;
    logic signed [16:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [17:0] iw_full, ih_full;
    logic               pos_a;

    always_comb
    begin
        n_l = 17'(item_reg.box_left);
        n_r = n_l + $signed({2'b00, item_reg.box_width});
        e_l = 17'(rd_entry.left);
        e_r = e_l + $signed({2'b00, rd_entry.wid});
        n_t = 17'(item_reg.box_top);
        n_b = n_t + $signed({2'b00, item_reg.box_height});
        e_t = 17'(rd_entry.top);
        e_b = e_t + $signed({2'b00, rd_entry.hei});
        lo_x = (n_l > e_l) ? n_l : e_l;
        hi_x = (n_r < e_r) ? n_r : e_r;
        lo_y = (n_t > e_t) ? n_t : e_t;
        hi_y = (n_b < e_b) ? n_b : e_b;
        iw_full = 18'(hi_x) - 18'(lo_x);
        ih_full = 18'(hi_y) - 18'(lo_y);
        pos_a   = (iw_full > 18'sd0) && (ih_full > 18'sd0);
    end

    // A positive overlap is never wider than the narrower box, so 15 bits hold it.
    logic hit;
    assign hit = vd_reg && cand_d_reg && ({1'b0, inter100_d_reg} > prod_d_reg);

    logic pipe_empty;
    assign pipe_empty = !(v0_reg || va_reg || vb_reg || vc_reg || vd_reg);

    logic full;
    assign full = (count_reg == COUNT_W'(TABLE_DEPTH));

    logic in_range;
    assign in_range = (32'(item_reg.read_index) < 32'(count_reg));

    out_result_t res;

    always_comb
    begin
        res        = '0;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[IDX_W-1:0];
        if (item_reg.opcode == OP_INSERT)
        begin
            if (found_reg)
            begin
                res.entry_index = 7'(match_idx_reg);
                mem_waddr       = match_idx_reg;
                if (better_reg)
                begin
                    res.status = ST_REPLACED;
                    mem_we     = cmd.finish;
                end
                else
                begin
                    res.status = ST_KEPT;
                end
            end
            else if (!full)
            begin
                res.status      = ST_APPENDED;
                res.entry_index = 7'(count_reg[IDX_W-1:0]);
                mem_we          = cmd.finish;
                count_next      = count_reg + 1'b1;
            end
            else
            begin
                res.status = ST_FULL;
            end
        end
        else if (item_reg.opcode == OP_CLEAR)
        begin
            res.status = ST_CLEARED;
            count_next = '0;
        end
        else
        begin
            res.status      = ST_READ;
            res.entry_index = item_reg.read_index;
            if (in_range)
            begin
                res.out_class  = rd_entry.cls;
                res.out_score  = rd_entry.score;
                res.out_width  = rd_entry.wid;
                res.out_height = rd_entry.hei;
                res.out_left   = rd_entry.left;
                res.out_top    = rd_entry.top;
            end
        end
        res.entry_count = 8'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg       <= PCT_RESET;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            v0_reg        <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pct_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
            if (cmd.load)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.load || cmd.flush)
            begin
                v0_reg <= 1'b0;
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
                vd_reg <= 1'b0;
            end
            else
            begin
                v0_reg <= cmd.issue;
                va_reg <= v0_reg;
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                vd_reg <= vc_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg     <= in_item;
            area_new_reg <= in_item.box_width * in_item.box_height;
        end
        if (hit)
        begin
            match_idx_reg <= idx_d_reg;
            better_reg    <= (item_reg.box_score > score_d_reg);
        end
        if (cmd.issue)
        begin
            idx0_reg <= scan_addr_reg[IDX_W-1:0];
        end
        if (cmd.finish)
        begin
            out_result_reg <= res;
        end

        idx_a_reg   <= idx0_reg;
        cand_a_reg  <= (rd_entry.cls == item_reg.box_class) && pos_a;
        iw_a_reg    <= iw_full[14:0];
        ih_a_reg    <= ih_full[14:0];
        wid_a_reg   <= rd_entry.wid;
        hei_a_reg   <= rd_entry.hei;
        score_a_reg <= rd_entry.score;

        idx_b_reg    <= idx_a_reg;
        cand_b_reg   <= cand_a_reg;
        inter_b_reg  <= iw_a_reg * ih_a_reg;
        area_e_b_reg <= wid_a_reg * hei_a_reg;
        score_b_reg  <= score_a_reg;

        idx_c_reg      <= idx_b_reg;
        cand_c_reg     <= cand_b_reg;
        uni_c_reg      <= 31'(area_new_reg) + 31'(area_e_b_reg) - 31'(inter_b_reg);
        inter100_c_reg <= (37'(inter_b_reg) << 6) + (37'(inter_b_reg) << 5)
                        + (37'(inter_b_reg) << 2);
        score_c_reg    <= score_b_reg;

        idx_d_reg      <= idx_c_reg;
        cand_d_reg     <= cand_c_reg;
        prod_d_reg     <= 38'(pct_reg) * 38'(uni_c_reg);
        inter100_d_reg <= inter100_c_reg;
        score_d_reg    <= score_c_reg;
    end

    assign stat.scan_done  = (scan_addr_reg == count_reg);
    assign stat.pipe_empty = pipe_empty;
    assign stat.hit        = hit;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    `ASSERT_PROP(a_write_after_drain, mem_we |-> pipe_empty)
    `ASSERT_PROP(a_finish_needs_slot, cmd.finish |-> (!out_valid_reg || !out_stall))
    `ASSERT_NEVER(a_second_hit, hit && $past(hit))

endmodule

`default_nettype wire
